// ===== hw/rtl/bfsa_pkg.sv =====
// Shared types, constants and helpers for the buffer free-stack allocator.
// Depends on nothing; every other file imports it.
package bfsa_pkg;

   localparam int IDX_W      = 10;
   localparam int ENTRIES_W  = 11;
   localparam int BYTES_W    = 17;
   localparam int ADDR_W64   = 64;
   localparam int COUNT_W    = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int PROD_W     = IDX_W + BYTES_W;

   localparam int POOL_DEPTH_DEFAULT = 1024;
   localparam int MAX_BATCH_DEFAULT  = 64;

   localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 11'd1024;
   localparam logic [BYTES_W-1:0]   BYTES_RESET   = 17'd2048;
   localparam logic [BYTES_W-1:0]   BYTES_DEFAULT = 17'd2048;
   localparam logic [ADDR_W64-1:0]  BASE_RESET    = 64'd0;

   // request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_ENTRIES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE    = 2'd2;

   typedef struct packed {
      logic               opcode;
      logic [COUNT_W-1:0] request_count;
      logic [IDX_W-1:0]   freed_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]    slot_index;
      logic [ADDR_W64-1:0] slot_address;
      logic                slot_valid;
      logic [COUNT_W-1:0]  granted_total;
      logic                last_of_run;
   } rsp_type;

   // stack commands from the sequencer
   typedef struct packed {
      logic             push;
      logic             pop;
      logic             refill;
      logic [IDX_W-1:0] push_index;
   } stk_ctl_type;

   // pool size clipped to the stack depth
   function automatic logic [31:0] sat_pool(input logic [ENTRIES_W-1:0] entries,
                                            input int unsigned depth);
      logic [31:0] ext;
      ext = 32'(entries);
      sat_pool = (ext > 32'(depth)) ? 32'(depth) : ext;
   endfunction

endpackage

// ===== hw/rtl/buffer_free_stack_allocator.sv =====
// Top level of the buffer free-stack allocator: csr registers, sequencer
// and output register. Depends on bfsa_pkg, bfsa_stack and bfsa_addr_unit.
//
// Usage:
//   req channel (req_valid / req_stall / req_data) carries one command per
//   transfer: allocate a batch of up to MAX_BATCH buffers, or free one.
//   rsp channel (rsp_valid / rsp_stall / rsp_data) returns one transfer per
//   granted buffer (index, address, count, last mark), or a single transfer
//   with slot_valid low when nothing could be granted. A free returns nothing.
//   csr port writes pool_entries, buffer_bytes or pool_base; writing
//   pool_entries makes the whole pool free again. Write only when idle.
// Sequence:
//   A free is taken straight from the idle state. An allocate of n buffers
//   steps through read, multiply and add for each buffer: each buffer needs
//   a stack read, a multiply and an add, all through the one stack read port
//   and the one shared address unit. A refused allocate passes the none state.
// Reset:
//   Synchronous reset frees all buffers (pool of 1024, size 2048, base 0)
//   without any clearing pass; the block takes requests right after it.
// Stall:
//   A stalled result holds in the output register; the sequencer waits at
//   its add step until the register frees up. A new request may be taken
//   while the final result of the previous one still waits.
module buffer_free_stack_allocator #(
   parameter int POOL_DEPTH = bfsa_pkg::POOL_DEPTH_DEFAULT,
   parameter int MAX_BATCH  = bfsa_pkg::MAX_BATCH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bfsa_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bfsa_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write_en,
   input  logic [bfsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bfsa_pkg::ADDR_W64-1:0]     csr_wdata
);
   import bfsa_pkg::*;

   localparam int TOP_W = $clog2(POOL_DEPTH + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_ADD  = 5'b01000,
      ST_NONE = 5'b10000
   } seq_state_type;

   seq_state_type       state_ff, state_in;
   logic [COUNT_W-1:0]  granted_ff, granted_in;
   logic [COUNT_W-1:0]  left_ff, left_in;     // buffers still to pop
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [ENTRIES_W-1:0] entries_ff, entries_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [ADDR_W64-1:0] base_ff, base_in;

   stk_ctl_type         stk_ctl;
   logic [TOP_W-1:0]    top;
   logic [TOP_W-1:0]    pool_size;
   logic [TOP_W-1:0]    refill_size;
   logic [IDX_W-1:0]    rd_index;
   logic [IDX_W-1:0]    slot_index;
   logic [ADDR_W64-1:0] slot_address;
   logic [BYTES_W-1:0]  size;
   logic [COUNT_W-1:0]  want;
   logic [COUNT_W-1:0]  grant;
   logic                req_take;
   logic                out_free;
   logic                mul_en;

   assign pool_size   = TOP_W'(sat_pool(entries_ff, POOL_DEPTH));
   assign refill_size = TOP_W'(sat_pool(csr_wdata[ENTRIES_W-1:0], POOL_DEPTH));
   assign size        = (bytes_ff == '0) ? BYTES_DEFAULT : bytes_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // batch size: saturate to MAX_BATCH, then to what the stack holds
   assign want  = (32'(req_data.request_count) > 32'(MAX_BATCH)) ?
                  COUNT_W'(MAX_BATCH) : req_data.request_count;
   assign grant = (32'(want) < 32'(top)) ? want : COUNT_W'(top);

   always_comb begin
      state_in     = state_ff;
      granted_in   = granted_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      entries_in   = entries_ff;
      bytes_in     = bytes_ff;
      base_in      = base_ff;
      stk_ctl      = '0;
      stk_ctl.push_index = req_data.freed_index;
      mul_en       = 1'b0;

      if (csr_write_en) begin
         case (csr_index)
            CSR_POOL_ENTRIES: begin
               entries_in     = csr_wdata[ENTRIES_W-1:0];
               stk_ctl.refill = 1'b1;
            end
            CSR_BUFFER_BYTES: bytes_in = csr_wdata[BYTES_W-1:0];
            CSR_POOL_BASE:    base_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.opcode == OP_FREE) begin
                  stk_ctl.push = 1'b1;
               end else if (grant == '0) begin
                  state_in = ST_NONE;
               end else begin
                  granted_in = grant;
                  left_in    = grant;
                  state_in   = ST_READ;
               end
            end
         end
         ST_READ: begin
            stk_ctl.pop = 1'b1;
            left_in     = left_ff - COUNT_W'(1);
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            mul_en   = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.slot_index    = slot_index;
               rsp_data_in.slot_address  = slot_address;
               rsp_data_in.slot_valid    = 1'b1;
               rsp_data_in.granted_total = granted_ff;
               rsp_data_in.last_of_run   = (left_ff == '0);
               state_in = (left_ff == '0) ? ST_IDLE : ST_READ;
            end
         end
         ST_NONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.last_of_run = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         entries_ff   <= ENTRIES_RESET;
         bytes_ff     <= BYTES_RESET;
         base_ff      <= BASE_RESET;
         granted_ff   <= '0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         entries_ff   <= entries_in;
         bytes_ff     <= bytes_in;
         base_ff      <= base_in;
         granted_ff   <= granted_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   bfsa_stack #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_stack (
      .clock       (clock),
      .reset       (reset),
      .ctl         (stk_ctl),
      .pool_size   (pool_size),
      .refill_size (refill_size),
      .top         (top),
      .rd_index    (rd_index)
   );

   bfsa_addr_unit u_addr (
      .clock     (clock),
      .mul_en    (mul_en),
      .index     (rd_index),
      .size      (size),
      .base      (base_ff),
      .index_out (slot_index),
      .address   (slot_address)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/bfsa_stack.sv =====
// LIFO of free buffer indices: index memory, top pointer and refill mark.
// Depends on bfsa_pkg.
module bfsa_stack #(
   parameter int POOL_DEPTH = bfsa_pkg::POOL_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bfsa_pkg::stk_ctl_type                ctl,
   input  logic [$clog2(POOL_DEPTH+1)-1:0]      pool_size,
   input  logic [$clog2(POOL_DEPTH+1)-1:0]      refill_size,
   output logic [$clog2(POOL_DEPTH+1)-1:0]      top,
   output logic [bfsa_pkg::IDX_W-1:0]           rd_index
);
   import bfsa_pkg::*;

   localparam int TOP_W = $clog2(POOL_DEPTH + 1);
   localparam int MEM_AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam logic [TOP_W-1:0] RESET_SIZE = TOP_W'(sat_pool(ENTRIES_RESET, POOL_DEPTH));

   logic [IDX_W-1:0] mem [POOL_DEPTH];

   logic [TOP_W-1:0] top_ff, top_in;
   // positions below low_ff were never written since the last refill
   logic [TOP_W-1:0] low_ff, low_in;
   logic [IDX_W-1:0] rd_mem_ff;
   logic [IDX_W-1:0] rd_pos_ff;
   logic             rd_init_ff;

   logic [TOP_W-1:0] pos;
   logic             can_push;

   assign pos      = top_ff - TOP_W'(1);
   assign can_push = top_ff < pool_size;

   always_comb begin
      top_in = top_ff;
      low_in = low_ff;
      if (ctl.refill) begin
         top_in = refill_size;
         low_in = refill_size;
      end else if (ctl.pop) begin
         top_in = pos;
         if (pos < low_ff) begin
            low_in = pos;
         end
      end else if (ctl.push && can_push) begin
         top_in = top_ff + TOP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= RESET_SIZE;
         low_ff <= RESET_SIZE;
      end else begin
         top_ff <= top_in;
         low_ff <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push && !ctl.refill && !ctl.pop && can_push) begin
         mem[top_ff[MEM_AW-1:0]] <= ctl.push_index;
      end
      if (ctl.pop) begin
         rd_mem_ff  <= mem[pos[MEM_AW-1:0]];
         rd_init_ff <= pos < low_ff;
         rd_pos_ff  <= IDX_W'(pos[MEM_AW-1:0]);
      end
   end

   assign top      = top_ff;
   assign rd_index = rd_init_ff ? rd_pos_ff : rd_mem_ff;

endmodule

// ===== hw/rtl/bfsa_addr_unit.sv =====
// Shared address unit: index times buffer size, then plus pool base.
// Depends on bfsa_pkg.
module bfsa_addr_unit (
   input  logic                           clock,
   input  logic                           mul_en,
   input  logic [bfsa_pkg::IDX_W-1:0]     index,
   input  logic [bfsa_pkg::BYTES_W-1:0]   size,
   input  logic [bfsa_pkg::ADDR_W64-1:0]  base,
   output logic [bfsa_pkg::IDX_W-1:0]     index_out,
   output logic [bfsa_pkg::ADDR_W64-1:0]  address
);
   import bfsa_pkg::*;

   logic [IDX_W-1:0]  idx_ff;
   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         idx_ff  <= index;
         prod_ff <= PROD_W'(index) * PROD_W'(size);
      end
   end

   // add step, registered by the output stage
   assign index_out = idx_ff;
   assign address   = base + ADDR_W64'(prod_ff);

endmodule

// ===== hw/rtl/bfsa_checker.sv =====
// Port-level checks for the buffer free-stack allocator, bound to the top.
// Depends on bfsa_pkg and buffer_free_stack_allocator.
module bfsa_checker #(
   parameter int MAX_BATCH = bfsa_pkg::MAX_BATCH_DEFAULT
) (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bfsa_pkg::rsp_type rsp_data
);
   import bfsa_pkg::*;

   // a stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // refused allocate: empty, final, zero count
   a_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.slot_valid |->
         rsp_data.last_of_run && (rsp_data.granted_total == '0) &&
         (rsp_data.slot_address == '0))
      else $error("malformed refused result");

   // granted buffer carries a count within the batch limit
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.slot_valid |->
         (rsp_data.granted_total != '0) &&
         (32'(rsp_data.granted_total) <= 32'(MAX_BATCH)))
      else $error("granted count out of range");

   // first cycle out of reset: no result pending and the request side open
   a_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("state after reset");

endmodule

bind buffer_free_stack_allocator bfsa_checker #(
   .MAX_BATCH (MAX_BATCH)
) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
